// ===== rtl/core/ecr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecr_pkg: shared types and constants of the event curve recorder
// Operation codes, sequencer states, the ms reciprocal and the CRC-32 step.
// ----------------------------------------------------------------------------
package ecr_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 256;
	localparam logic [15:0] MAX_DURATION_RST = 16'd60000;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	// floor(x / 1000) == (x * RECIP_MS) >> MS_SHIFT for every 32-bit x.
	localparam logic [28:0] RECIP_MS = 29'd274877907;
	localparam int unsigned MS_SHIFT = 38;
	localparam int unsigned PROD_W = 61;
	localparam int unsigned ELAPSED_W = 23;
	localparam logic [15:0] NONE_INDEX = 16'hFFFF;
	localparam int unsigned IN_DATA_W = 72;
	localparam int unsigned OUT_DATA_W = 136;

	typedef enum logic [2:0] {
		OP_RESET   = 3'd0,
		OP_BEGIN   = 3'd1,
		OP_ADVANCE = 3'd2,
		OP_LAUNCH  = 3'd3,
		OP_CAPTURE = 3'd4,
		OP_FINISH  = 3'd5,
		OP_MARK    = 3'd6,
		OP_READ    = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_EXEC,
		ST_NRD,
		ST_NCMP,
		ST_CRD,
		ST_CLOAD,
		ST_CBYTE,
		ST_RRD,
		ST_RDAT,
		ST_DONE
	} state_t;

	// One byte through the reflected CRC-32, eight bit steps.
	function automatic logic [31:0] crc_step_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ecr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ecr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/event_curve_recorder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// event_curve_recorder: timestamped RPM curve capture with CRC-32
// Each item passes ST_MUL and ST_EXEC before its result leaves from ST_DONE; a read also
// passes ST_RRD and ST_RDAT. Launch walks every stored sample for the nearest one. Finish
// runs the CRC over every sample (one CRC byte a cycle), then the nearest-launch search
// after a launch. One item is in work at a time; a result waiting on the master side
// does not stop the next transfer. The asynchronous reset clears all control and record
// state at once; the sample RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module event_curve_recorder
	import ecr_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = ecr_pkg::MAX_SAMPLES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	// tdata: time_us[31:0], rpm[47:32], is_max[48], sample_index[64:49], zero pad
	input  wire [ecr_pkg::IN_DATA_W-1:0] s_tdata,
	// tuser: operation[2:0]
	input  wire [2:0]  s_tuser,
	output logic       m_tvalid,
	input  wire        m_tready,
	// tdata: read_valid[0], active[1], ready_res[2], truncated[3], count[19:4],
	// duration[35:20], launch_ok[36], launch_index[52:37],
	// peak_ms[68:53], crc32[100:69], sample_time_ms[116:101],
	// sample_rpm[132:117], zero pad
	output logic [ecr_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [2:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	localparam int unsigned AW = $clog2(MAX_SAMPLES);
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

	state_t state_q, state_d;

	// Item fields held for the whole sequence.
	op_t         op_q;
	logic [31:0] time_q;
	logic [15:0] rpm_q;
	logic        ismax_q;
	logic [15:0] idx_q;

	// Elapsed time path: difference, then one multiply by the reciprocal.
	logic [31:0]        diff_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ELAPSED_W-1:0] elapsed;
	logic               over_cap;

	// Record state.
	logic [31:0] start_q;
	logic [CW-1:0] count_q;
	logic        active_q, ready_q, trunc_q, capped_q, launch_v_q;
	logic [15:0] dur_q, launch_t_q, near_q, peak_q, maxdur_q;
	logic [31:0] crc_q;

	// Walk state for the nearest search and the CRC pass.
	logic [CW-1:0] walk_q;
	logic [16:0]   best_q;
	logic [15:0]   target_q;
	logic [31:0]   word_q;
	logic [1:0]    byte_q;

	// Read-back result.
	logic        rv_q;
	logic [15:0] stime_q, srpm_q;

	logic        m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// Sample RAM: time in the low half, rpm in the high half.
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic in_xfer, out_free, walk_more, read_hit;
	logic [15:0] sample_gap;

	ecr_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign prdata   = {16'd0, maxdur_q};

	assign elapsed    = prod_q[MS_SHIFT +: ELAPSED_W];
	assign over_cap   = elapsed > ELAPSED_W'(maxdur_q);
	assign walk_more  = walk_q < count_q;
	assign read_hit   = {16'd0, idx_q} < {{(32-CW){1'b0}}, count_q};
	assign sample_gap = (ram_rdata[15:0] > target_q) ? ram_rdata[15:0] - target_q
	                                                 : target_q - ram_rdata[15:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_xfer) state_d = ST_MUL;
			ST_MUL:   state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (op_q)
					OP_LAUNCH:
						if (active_q && !capped_q && !over_cap) state_d = ST_NRD;
					OP_FINISH: if (active_q) state_d = ST_CRD;
					OP_READ:   if (read_hit) state_d = ST_RRD;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_NRD:   state_d = walk_more ? ST_NCMP : ST_DONE;
			ST_NCMP:  state_d = ST_NRD;
			ST_CRD: begin
				if (walk_more) state_d = ST_CLOAD;
				else if (launch_v_q) state_d = ST_NRD;
				else state_d = ST_DONE;
			end
			ST_CLOAD: state_d = ST_CBYTE;
			ST_CBYTE: state_d = (byte_q == 2'd3) ? ST_CRD : ST_CBYTE;
			ST_RRD:   state_d = ST_RDAT;
			ST_RDAT:  state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {rpm_q, elapsed[15:0]};
		ram_raddr = walk_q[AW-1:0];
		unique case (state_q)
			ST_EXEC: begin
				if (op_q == OP_BEGIN) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = '0;
				end else if (op_q == OP_CAPTURE && active_q && !capped_q && !over_cap
				             && count_q < MAX_CNT) begin
					ram_we = 1'b1;
				end
			end
			ST_RRD:  ram_raddr = idx_q[AW-1:0];
			default: ram_raddr = walk_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			maxdur_q   <= MAX_DURATION_RST;
			start_q    <= '0;
			count_q    <= '0;
			active_q   <= 1'b0;
			ready_q    <= 1'b0;
			trunc_q    <= 1'b0;
			capped_q   <= 1'b0;
			dur_q      <= '0;
			launch_t_q <= '0;
			launch_v_q <= 1'b0;
			near_q     <= NONE_INDEX;
			peak_q     <= '0;
			crc_q      <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && !paddr[2]) begin
				maxdur_q <= pwdata[15:0];
			end
			// A new result may replace the one taken in the same cycle.
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXEC: begin
					unique case (op_q)
						OP_RESET, OP_BEGIN: begin
							start_q    <= (op_q == OP_BEGIN) ? time_q : 32'd0;
							count_q    <= (op_q == OP_BEGIN) ? CW'(1) : '0;
							active_q   <= (op_q == OP_BEGIN);
							ready_q    <= 1'b0;
							trunc_q    <= 1'b0;
							capped_q   <= 1'b0;
							dur_q      <= '0;
							launch_t_q <= '0;
							launch_v_q <= 1'b0;
							near_q     <= NONE_INDEX;
							peak_q     <= '0;
							crc_q      <= '0;
						end
						OP_ADVANCE: begin
							if (active_q && !capped_q) begin
								if (over_cap) begin
									trunc_q  <= 1'b1;
									capped_q <= 1'b1;
									dur_q    <= maxdur_q;
								end else begin
									dur_q <= elapsed[15:0];
								end
							end
						end
						OP_LAUNCH: begin
							if (active_q) begin
								if (capped_q || over_cap) begin
									trunc_q <= 1'b1;
								end else begin
									launch_t_q <= elapsed[15:0];
									launch_v_q <= 1'b1;
								end
							end
						end
						OP_CAPTURE: begin
							if (active_q && !capped_q) begin
								if (over_cap || count_q >= MAX_CNT) begin
									trunc_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
									dur_q   <= elapsed[15:0];
									if (ismax_q) peak_q <= elapsed[15:0];
								end
							end
						end
						OP_FINISH: begin
							if (active_q) begin
								// The advance step and the final cap collapse into one:
								// once over the cap the duration pins at the cap.
								if (!capped_q && over_cap) begin
									trunc_q  <= 1'b1;
									capped_q <= 1'b1;
								end
								dur_q    <= (capped_q || over_cap) ? maxdur_q : elapsed[15:0];
								active_q <= 1'b0;
								ready_q  <= 1'b1;
								crc_q    <= CRC_INIT;
							end
						end
						OP_MARK: if (active_q) trunc_q <= 1'b1;
						default: ;
					endcase
				end
				ST_NCMP: begin
					if ({1'b0, sample_gap} < best_q) near_q <= 16'(walk_q);
				end
				ST_CRD:  if (!walk_more) crc_q <= ~crc_q;
				ST_CBYTE: crc_q <= crc_step_byte(crc_q, word_q[7:0]);
				default: ;
			endcase
		end
	end

	// Payload and walk registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op_t'(s_tuser);
			time_q  <= s_tdata[31:0];
			rpm_q   <= s_tdata[47:32];
			ismax_q <= s_tdata[48];
			idx_q   <= s_tdata[64:49];
			diff_q  <= s_tdata[31:0] - start_q;
		end
		unique case (state_q)
			ST_MUL: prod_q <= PROD_W'(diff_q * RECIP_MS);
			ST_EXEC: begin
				rv_q     <= 1'b0;
				stime_q  <= '0;
				srpm_q   <= '0;
				walk_q   <= '0;
				best_q   <= '1;
				target_q <= elapsed[15:0];
			end
			ST_NCMP: begin
				if ({1'b0, sample_gap} < best_q) best_q <= {1'b0, sample_gap};
				walk_q <= walk_q + CW'(1);
			end
			ST_CRD: begin
				if (!walk_more) begin
					walk_q   <= '0;
					best_q   <= '1;
					target_q <= launch_t_q;
				end
			end
			ST_CLOAD: begin
				word_q <= ram_rdata;
				byte_q <= 2'd0;
			end
			ST_CBYTE: begin
				word_q <= word_q >> 8;
				byte_q <= byte_q + 2'd1;
				if (byte_q == 2'd3) walk_q <= walk_q + CW'(1);
			end
			ST_RDAT: begin
				rv_q    <= 1'b1;
				stime_q <= ram_rdata[15:0];
				srpm_q  <= ram_rdata[31:16];
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {3'd0, srpm_q, stime_q, crc_q, peak_q, near_q, launch_v_q,
					              dur_q, 16'(count_q), trunc_q, ready_q, active_q, rv_q};
				end
			end
			default: ;
		endcase
	end

	// A new transfer is only taken with the sequencer at rest.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE))
		else $error("input taken while sequencer busy");
	// The stored count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("sample count beyond store depth");
	// A nearest index exists only after a launch was latched.
	a_near_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(near_q != NONE_INDEX) |-> launch_v_q)
		else $error("nearest index without launch");
	// A record is never active and finished at once.
	a_active_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(active_q && ready_q))
		else $error("record active and ready together");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the event curve recorder
// Drives directed and random record sequences over the stream port, changes
// the duration cap over the register port between phases and checks every
// status transfer, field by field, against a behavioral predictor or a fixed row status.
// ----------------------------------------------------------------------------
module testbench;
	import ecr_pkg::*;

	localparam logic [2:0] REG_MAX_DURATION = 3'd0;
	localparam int unsigned STORE_DEPTH = MAX_SAMPLES_DEF;
	localparam int unsigned ITEMS_PER_PHASE = 370;
	localparam int unsigned NUM_PHASES = 5;

	// One result transfer, unpacked into its fields.
	typedef struct {
		logic        read_valid;
		logic        active;
		logic        ready_res;
		logic        truncated;
		logic [15:0] count;
		logic [15:0] run_ms;
		logic        launch_ok;
		logic [15:0] launch_idx;
		logic [15:0] peak_ms;
		logic [31:0] crc32;
		logic [15:0] sample_time_ms;
		logic [15:0] sample_rpm;
	} status_t;

	typedef struct {
		op_t         op;
		logic [31:0] time_us;
		logic [15:0] rpm;
		logic        is_max;
		logic [15:0] index;
		logic        fixed;
		status_t     status;
	} stim_row_t;

	localparam status_t IDLE_STATUS = '{read_valid: 1'b0, active: 1'b0, ready_res: 1'b0,
		truncated: 1'b0, count: 16'd0, run_ms: 16'd0, launch_ok: 1'b0,
		launch_idx: NONE_INDEX, peak_ms: 16'd0, crc32: 32'd0, sample_time_ms: 16'd0,
		sample_rpm: 16'd0};
	localparam status_t BEGUN_STATUS = '{read_valid: 1'b0, active: 1'b1, ready_res: 1'b0,
		truncated: 1'b0, count: 16'd1, run_ms: 16'd0, launch_ok: 1'b0,
		launch_idx: NONE_INDEX, peak_ms: 16'd0, crc32: 32'd0, sample_time_ms: 16'd0,
		sample_rpm: 16'd0};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Predictor state: a private copy of the record and of the cap register.
	logic [31:0] curve_store [STORE_DEPTH];
	logic [31:0] curve_start_us;
	int unsigned curve_count;
	logic        curve_active;
	logic        curve_ready;
	logic        curve_truncated;
	logic        curve_capped;
	logic [15:0] curve_duration;
	logic [15:0] curve_launch_ms;
	logic        curve_launched;
	logic [15:0] curve_nearest;
	logic [15:0] curve_peak;
	logic [31:0] curve_crc;
	logic [15:0] cap_ms;

	status_t     expected_status [$];
	int unsigned items_sent;
	int unsigned errors;
	logic        steady;

	event_curve_recorder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard limit on the whole run, far beyond the slowest correct run.
	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic void clear_curve();
		curve_start_us = 32'd0;
		curve_count = 0;
		curve_active = 1'b0;
		curve_ready = 1'b0;
		curve_truncated = 1'b0;
		curve_capped = 1'b0;
		curve_duration = 16'd0;
		curve_launch_ms = 16'd0;
		curve_launched = 1'b0;
		curve_nearest = NONE_INDEX;
		curve_peak = 16'd0;
		curve_crc = 32'd0;
	endfunction

	// Elapsed milliseconds since begin, with the microsecond counter wrapping.
	function automatic logic [31:0] ms_since_start(logic [31:0] t);
		logic [31:0] diff;
		diff = t - curve_start_us;
		return diff / 32'd1000;
	endfunction

	// Nearest stored sample time; a strict compare keeps the first one on ties.
	function automatic void search_nearest(logic [31:0] target);
		logic [31:0] best;
		logic [31:0] st;
		logic [31:0] gap;
		best = 32'hFFFF_FFFF;
		for (int unsigned i = 0; i < curve_count; i++) begin
			st = {16'd0, curve_store[i][15:0]};
			gap = (st > target) ? st - target : target - st;
			if (gap < best) begin
				best = gap;
				curve_nearest = i[15:0];
			end
		end
	endfunction

	function automatic void advance_curve(logic [31:0] t);
		logic [31:0] e;
		if (curve_active && !curve_capped) begin
			e = ms_since_start(t);
			if (e > {16'd0, cap_ms}) begin
				curve_truncated = 1'b1;
				curve_capped = 1'b1;
				e = {16'd0, cap_ms};
			end
			curve_duration = e[15:0];
		end
	endfunction

	// Reflected CRC-32 over the time and rpm bytes of every stored sample.
	function automatic logic [31:0] curve_checksum();
		logic [31:0] c;
		c = 32'hFFFF_FFFF;
		for (int unsigned i = 0; i < curve_count; i++) begin
			for (int b = 0; b < 4; b++) begin
				c = c ^ {24'd0, curve_store[i][8*b +: 8]};
				for (int k = 0; k < 8; k++) begin
					c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
				end
			end
		end
		return ~c;
	endfunction

	// Applies one item to the predictor and returns the status it reports.
	function automatic status_t predict_status(op_t op, logic [31:0] t, logic [15:0] rpm,
			logic is_max, logic [15:0] index);
		status_t s;
		logic [31:0] e;
		s = IDLE_STATUS;
		case (op)
			OP_RESET: begin
				clear_curve();
			end
			OP_BEGIN: begin
				clear_curve();
				curve_active = 1'b1;
				curve_start_us = t;
				curve_store[0] = 32'd0;
				curve_count = 1;
			end
			OP_ADVANCE: begin
				advance_curve(t);
			end
			OP_LAUNCH: begin
				if (curve_active) begin
					e = ms_since_start(t);
					if (curve_capped || e > {16'd0, cap_ms}) begin
						curve_truncated = 1'b1;
					end else begin
						curve_launch_ms = e[15:0];
						curve_launched = 1'b1;
						search_nearest(e);
					end
				end
			end
			OP_CAPTURE: begin
				if (curve_active && !curve_capped) begin
					e = ms_since_start(t);
					if (e > {16'd0, cap_ms} || curve_count >= STORE_DEPTH) begin
						curve_truncated = 1'b1;
					end else begin
						curve_store[curve_count] = {rpm, e[15:0]};
						curve_count++;
						curve_duration = e[15:0];
						if (is_max) begin
							curve_peak = e[15:0];
						end
					end
				end
			end
			OP_FINISH: begin
				if (curve_active) begin
					advance_curve(t);
					if (curve_capped) begin
						e = {16'd0, cap_ms};
					end else begin
						e = ms_since_start(t);
						if (e > {16'd0, cap_ms}) begin
							e = {16'd0, cap_ms};
							curve_truncated = 1'b1;
						end
					end
					curve_duration = e[15:0];
					curve_active = 1'b0;
					curve_ready = 1'b1;
					curve_crc = curve_checksum();
					if (curve_launched) begin
						search_nearest({16'd0, curve_launch_ms});
					end
				end
			end
			OP_MARK: begin
				if (curve_active) begin
					curve_truncated = 1'b1;
				end
			end
			default: begin
				if (index < curve_count) begin
					s.read_valid = 1'b1;
					s.sample_time_ms = curve_store[index][15:0];
					s.sample_rpm = curve_store[index][31:16];
				end
			end
		endcase
		s.active = curve_active;
		s.ready_res = curve_ready;
		s.truncated = curve_truncated;
		s.count = curve_count[15:0];
		s.run_ms = curve_duration;
		s.launch_ok = curve_launched;
		s.launch_idx = curve_nearest;
		s.peak_ms = curve_peak;
		s.crc32 = curve_crc;
		return s;
	endfunction

	// Sends one item: an optional idle gap first, then holds tvalid until the
	// transfer. The expectation is queued in transfer order.
	task automatic send_item(op_t op, logic [31:0] t, logic [15:0] rpm, logic is_max,
			logic [15:0] index, logic fixed = 1'b0, status_t fixed_status = IDLE_STATUS);
		status_t s;
		s = predict_status(op, t, rpm, is_max, index);
		steady = (items_sent >= 500 && items_sent < 800);
		if (!steady && $urandom_range(0, 99) < 26) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, index, is_max, rpm, t};
		do @(posedge clk); while (!s_tready);
		if (fixed) begin
			expected_status.push_back(fixed_status);
		end else begin
			expected_status.push_back(s);
		end
		items_sent++;
	endtask

	// Lets every outstanding result drain so the block is idle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_cap(logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MAX_DURATION;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_ms = value;
	endtask

	// One record: begin, a random mix of events with captures dominating,
	// usually a finish and some read-back. A few records fill the store.
	task automatic random_record();
		logic [31:0] first_us;
		logic [31:0] now_us;
		int unsigned step_max;
		int unsigned n;
		int unsigned k;
		logic        fill;
		first_us = $urandom;
		now_us = first_us;
		case ($urandom_range(0, 3))
			0: step_max = 999;
			1: step_max = 5000;
			2: step_max = 200_000;
			default: step_max = 5_000_000;
		endcase
		fill = ($urandom_range(0, 29) == 0);
		n = fill ? 262 : $urandom_range(0, 14);
		if (fill) begin
			step_max = 999;
		end
		send_item(OP_BEGIN, first_us, 16'($urandom), 1'($urandom), 16'($urandom));
		for (int unsigned i = 0; i < n; i++) begin
			now_us += $urandom_range(0, step_max);
			k = fill ? 0 : $urandom_range(0, 99);
			if (k < 68) begin
				send_item(OP_CAPTURE, now_us, 16'($urandom), 1'($urandom), 16'($urandom));
			end else if (k < 78) begin
				send_item(OP_ADVANCE, now_us, 16'($urandom), 1'($urandom), 16'($urandom));
			end else if (k < 87) begin
				send_item(OP_LAUNCH, first_us + $urandom_range(0, now_us - first_us + step_max),
					16'($urandom), 1'($urandom), 16'($urandom));
			end else if (k < 90) begin
				send_item(OP_MARK, now_us, 16'($urandom), 1'($urandom), 16'($urandom));
			end else if (k < 96) begin
				send_item(OP_READ, $urandom, 16'($urandom), 1'($urandom),
					16'($urandom_range(0, curve_count)));
			end else begin
				send_item(op_t'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'($urandom),
					16'($urandom));
			end
		end
		k = $urandom_range(0, 9);
		if (k < 8) begin
			send_item(OP_FINISH, now_us + $urandom_range(0, step_max), 16'($urandom),
				1'($urandom), 16'($urandom));
		end else if (k == 8) begin
			send_item(OP_RESET, $urandom, 16'($urandom), 1'($urandom), 16'($urandom));
		end
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 3) == 0) begin
				send_item(OP_READ, $urandom, 16'($urandom), 1'($urandom), 16'($urandom));
			end else begin
				send_item(OP_READ, $urandom, 16'($urandom), 1'($urandom),
					16'($urandom_range(0, curve_count)));
			end
		end
	endtask

	// Receiver side: stalls at random outside the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 26);
	end

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// Each result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		status_t exp_s;
		if (m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
				errors++;
			end else begin
				exp_s = expected_status.pop_front();
				check_field("read_valid", 32'(exp_s.read_valid), 32'(m_tdata[0]));
				check_field("active", 32'(exp_s.active), 32'(m_tdata[1]));
				check_field("ready_res", 32'(exp_s.ready_res), 32'(m_tdata[2]));
				check_field("truncated", 32'(exp_s.truncated), 32'(m_tdata[3]));
				check_field("count", 32'(exp_s.count), 32'(m_tdata[19:4]));
				check_field("duration", 32'(exp_s.run_ms), 32'(m_tdata[35:20]));
				check_field("launch ok", 32'(exp_s.launch_ok), 32'(m_tdata[36]));
				check_field("launch index", 32'(exp_s.launch_idx), 32'(m_tdata[52:37]));
				check_field("peak time", 32'(exp_s.peak_ms), 32'(m_tdata[68:53]));
				check_field("crc32", exp_s.crc32, m_tdata[100:69]);
				check_field("sample_time_ms", 32'(exp_s.sample_time_ms),
					32'(m_tdata[116:101]));
				check_field("sample_rpm", 32'(exp_s.sample_rpm), 32'(m_tdata[132:117]));
			end
		end
	end

	initial begin
		// Directed rows. The record starts 1000 us before the counter wraps, so
		// the first capture's elapsed time crosses the wrap. Launch at 6 ms lies
		// halfway between samples at 1 ms and 11 ms and must pick the first.
		stim_row_t directed_rows [] = '{
			'{OP_READ,    32'd0,          16'd0,      1'b0, 16'd0,      1'b1, IDLE_STATUS},
			'{OP_ADVANCE, 32'hFFFF_FFFF,  16'd0,      1'b0, 16'd0,      1'b1, IDLE_STATUS},
			'{OP_CAPTURE, 32'd1234,       16'hFFFF,   1'b1, 16'd0,      1'b1, IDLE_STATUS},
			'{OP_BEGIN,   32'hFFFF_FC18,  16'hFFFF,   1'b1, 16'hFFFF,   1'b1, BEGUN_STATUS},
			'{OP_CAPTURE, 32'd500,        16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_CAPTURE, 32'd10000,      16'hFFFF,   1'b1, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_LAUNCH,  32'd5000,       16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_LAUNCH,  32'd6000,       16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_READ,    32'd0,          16'd0,      1'b0, 16'd1,      1'b0, IDLE_STATUS},
			'{OP_READ,    32'd0,          16'd0,      1'b0, 16'd2,      1'b0, IDLE_STATUS},
			'{OP_READ,    32'd0,          16'd0,      1'b0, 16'd3,      1'b0, IDLE_STATUS},
			'{OP_READ,    32'hFFFF_FFFF,  16'hFFFF,   1'b1, 16'hFFFF,   1'b0, IDLE_STATUS},
			'{OP_MARK,    32'd0,          16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_ADVANCE, 32'd60999000,   16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_CAPTURE, 32'd61999000,   16'd7,      1'b1, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_LAUNCH,  32'd1000,       16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_FINISH,  32'd0,          16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_READ,    32'd0,          16'd0,      1'b0, 16'd2,      1'b0, IDLE_STATUS},
			'{OP_MARK,    32'd0,          16'd0,      1'b0, 16'd0,      1'b0, IDLE_STATUS},
			'{OP_RESET,   32'hFFFF_FFFF,  16'hFFFF,   1'b1, 16'hFFFF,   1'b1, IDLE_STATUS},
			'{OP_FINISH,  32'd99999,      16'd0,      1'b0, 16'd0,      1'b1, IDLE_STATUS}
		};
		logic [15:0] phase_caps [NUM_PHASES] = '{16'd60000, 16'd0, 16'd65535, 16'd500, 16'd3000};

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_RESET;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = REG_MAX_DURATION;
		pwdata = 32'd0;
		items_sent = 0;
		errors = 0;
		steady = 1'b0;
		cap_ms = MAX_DURATION_RST;
		clear_curve();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_item(directed_rows[r].op, directed_rows[r].time_us, directed_rows[r].rpm,
				directed_rows[r].is_max, directed_rows[r].index, directed_rows[r].fixed,
				directed_rows[r].status);
		end

		// Each phase runs under its own cap; the cap only changes while idle.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				write_cap((p == NUM_PHASES - 1) ? 16'($urandom_range(100, 65000)) : phase_caps[p]);
			end
			while (items_sent < (p + 1) * ITEMS_PER_PHASE) begin
				random_record();
			end
		end

		drain_results();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ecr_pkg.sv
rtl/core/ecr_ram.sv
rtl/core/event_curve_recorder.sv
test/testbench.sv
